// ----- hw/rtl/mgbr_pkg.sv -----
// Shared types and constants for the monochrome glyph rasteriser.
package mgbr_pkg;

  localparam int COORD_W     = 16;
  localparam int DIM_W       = 8;
  localparam int COLOR_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int BIT_IDX_W   = $clog2(BYTE_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_DATA = 1'b1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]          glyph_width;
    logic [DIM_W-1:0]          glyph_height;
    logic [COLOR_W-1:0]        pixel_color;
    logic [BYTE_W-1:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        out_color;
    logic                      last_of_byte;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic               empty;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
    logic [COLOR_W-1:0] pixel_color;
    logic [BYTE_W-1:0]  data_byte;
  } cmd_t;

endpackage

// ----- hw/rtl/mgbr_front.sv -----
// Front end: accept input beats, classify them and queue them for the back end.
module mgbr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mgbr_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output mgbr_pkg::cmd_t    q_data
);
  import mgbr_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              wr_en;
  logic              rd_en;

  // Classify: tag the item and flag an empty glyph up front.
  always_comb begin
    cmd_in.op           = (in_data.kind == KIND_DATA) ? CMD_BYTE : CMD_START;
    cmd_in.empty        = (in_data.glyph_width == '0) || (in_data.glyph_height == '0);
    cmd_in.origin_x     = in_data.origin_x;
    cmd_in.origin_y     = in_data.origin_y;
    cmd_in.glyph_width  = in_data.glyph_width;
    cmd_in.glyph_height = in_data.glyph_height;
    cmd_in.pixel_color  = in_data.pixel_color;
    cmd_in.data_byte    = in_data.data_byte;
  end

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_data   = entry[rd_ptr];
  assign wr_en    = in_valid && in_ready;
  assign rd_en    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

// ----- hw/rtl/mgbr_back.sv -----
// Back end: hold glyph state, scan bytes a bit per unstalled cycle, register pixels.
module mgbr_back #(
  parameter int COLOR_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  mgbr_pkg::cmd_t     q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mgbr_pkg::out_item_t out_data
);
  import mgbr_pkg::*;

  localparam int KEEP_W = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;

  state_t             state;
  state_t             state_next;
  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;
  logic [KEEP_W-1:0]  draw_color;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [DIM_W-1:0]   col_count;
  logic [DIM_W-1:0]   row_count;
  logic               glyph_active;
  logic [BYTE_W-1:0]  byte_sh;
  logic [BIT_IDX_W-1:0] bit_cnt;
  logic               pend_valid;
  logic [COORD_W-1:0] pend_x;
  logic [COORD_W-1:0] pend_y;

  logic [COORD_W-1:0] base_x_next;
  logic [COORD_W-1:0] base_y_next;
  logic [KEEP_W-1:0]  draw_color_next;
  logic [DIM_W-1:0]   width_reg_next;
  logic [DIM_W-1:0]   height_reg_next;
  logic [DIM_W-1:0]   col_count_next;
  logic [DIM_W-1:0]   row_count_next;
  logic               glyph_active_next;
  logic [BYTE_W-1:0]  byte_sh_next;
  logic [BIT_IDX_W-1:0] bit_cnt_next;
  logic               pend_valid_next;
  logic [COORD_W-1:0] pend_x_next;
  logic [COORD_W-1:0] pend_y_next;

  logic               hit;
  logic [DIM_W:0]     col_plus;
  logic [DIM_W:0]     row_plus;
  logic               row_end;
  logic               glyph_end;
  logic               done;
  logic [COORD_W-1:0] new_x;
  logic [COORD_W-1:0] new_y;
  logic               out_free;
  logic               push_req;
  logic               push;
  out_item_t          push_data;
  logic               scan_go;
  logic               flush_go;
  logic               pop;
  logic               active_after;
  logic               pop_byte_go;

  // Decode the current scan step.
  always_comb begin
    hit       = byte_sh[BYTE_W-1];
    col_plus  = {1'b0, col_count} + 1'b1;
    row_plus  = {1'b0, row_count} + 1'b1;
    row_end   = (col_plus >= {1'b0, width_reg});
    glyph_end = row_end && (row_plus >= {1'b0, height_reg});
    done      = (bit_cnt == BIT_IDX_W'(BYTE_W - 1)) || glyph_end;
    new_x     = base_x + {{(COORD_W-DIM_W){1'b0}}, col_count};
    new_y     = base_y + {{(COORD_W-DIM_W){1'b0}}, row_count};
  end

  assign out_free = !out_valid || out_ready;

  // Outputs of the sequencer: pixel pushes, step enables and queue pop.
  always_comb begin
    push_req  = 1'b0;
    push_data = '0;
    push_data.out_color = COLOR_W'(draw_color);
    case (state)
      ST_SCAN: begin
        if (hit && pend_valid) begin
          push_req               = 1'b1;
          push_data.pixel_x      = pend_x;
          push_data.pixel_y      = pend_y;
          push_data.last_of_byte = 1'b0;
        end else if (done && hit) begin
          push_req               = 1'b1;
          push_data.pixel_x      = new_x;
          push_data.pixel_y      = new_y;
          push_data.last_of_byte = 1'b1;
        end else if (done && pend_valid) begin
          push_req               = 1'b1;
          push_data.pixel_x      = pend_x;
          push_data.pixel_y      = pend_y;
          push_data.last_of_byte = 1'b1;
        end
      end
      ST_FLUSH: begin
        push_req               = 1'b1;
        push_data.pixel_x      = pend_x;
        push_data.pixel_y      = pend_y;
        push_data.last_of_byte = 1'b1;
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
    push         = push_req && out_free;
    scan_go      = (state == ST_SCAN) && (!push_req || out_free);
    flush_go     = (state == ST_FLUSH) && out_free;
    active_after = (scan_go && glyph_end) ? 1'b0 : glyph_active;
    pop          = q_valid && ((state == ST_IDLE) ||
                   (scan_go && done && !(hit && pend_valid)));
    pop_byte_go  = pop && (q_data.op == CMD_BYTE) && active_after;
    q_ready      = pop;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_byte_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_go && done) begin
          if (hit && pend_valid) begin
            state_next = ST_FLUSH;
          end else if (pop_byte_go) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Glyph and scan registers.
  always_comb begin
    base_x_next       = base_x;
    base_y_next       = base_y;
    draw_color_next   = draw_color;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    col_count_next    = col_count;
    row_count_next    = row_count;
    glyph_active_next = glyph_active;
    byte_sh_next      = byte_sh;
    bit_cnt_next      = bit_cnt;
    pend_valid_next   = pend_valid;
    pend_x_next       = pend_x;
    pend_y_next       = pend_y;

    if (scan_go) begin
      byte_sh_next = {byte_sh[BYTE_W-2:0], 1'b0};
      bit_cnt_next = bit_cnt + 1'b1;
      if (row_end) begin
        col_count_next = '0;
        row_count_next = row_plus[DIM_W-1:0];
      end else begin
        col_count_next = col_plus[DIM_W-1:0];
      end
      if (glyph_end) begin
        glyph_active_next = 1'b0;
      end
      if (hit && !(done && !pend_valid)) begin
        pend_valid_next = 1'b1;
        pend_x_next     = new_x;
        pend_y_next     = new_y;
      end
      if (done && !(hit && pend_valid)) begin
        pend_valid_next = 1'b0;
      end
    end

    if (flush_go) begin
      pend_valid_next = 1'b0;
    end

    // A start overrides whatever the final scan step left behind.
    if (pop && (q_data.op == CMD_START)) begin
      base_x_next       = q_data.origin_x;
      base_y_next       = q_data.origin_y;
      width_reg_next    = q_data.glyph_width;
      height_reg_next   = q_data.glyph_height;
      draw_color_next   = q_data.pixel_color[KEEP_W-1:0];
      col_count_next    = '0;
      row_count_next    = '0;
      glyph_active_next = !q_data.empty;
    end
    if (pop_byte_go) begin
      byte_sh_next = q_data.data_byte;
      bit_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_x       <= '0;
      base_y       <= '0;
      draw_color   <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      col_count    <= '0;
      row_count    <= '0;
      glyph_active <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      base_x       <= base_x_next;
      base_y       <= base_y_next;
      draw_color   <= draw_color_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
      glyph_active <= glyph_active_next;
      pend_valid   <= pend_valid_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_sh <= byte_sh_next;
    bit_cnt <= bit_cnt_next;
    pend_x  <= pend_x_next;
    pend_y  <= pend_y_next;
    if (push) begin
      out_data <= push_data;
    end
  end

  a_flush_has_pixel: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> pend_valid)
    else $error("flush without a held pixel");

  a_scan_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> glyph_active)
    else $error("scanning with no glyph in progress");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held pixel left over after a byte");

  a_counts_in_glyph: assert property (@(posedge clk) disable iff (rst)
    glyph_active |-> ((col_count < width_reg) && (row_count < height_reg)))
    else $error("column or row count outside the glyph");

endmodule

// ----- hw/rtl/mono_glyph_bitmap_rasterizer_unit.sv -----
// Top level of the monochrome 1bpp glyph rasteriser.
//
// Input channel (in_valid/in_ready/in_data): a beat of kind start latches
// the glyph origin, width, height and colour and rewinds the column and row
// counts; a beat of kind data carries the next packed bitmap byte, MSB
// first, with bits running on across row ends.
// Output channel (out_valid/out_ready/out_data): one beat per set pixel
// inside the glyph, coordinates wrapped to 16 bits, last_of_byte marking
// the final pixel that a byte produced.
// Beats pass through a two-entry queue to a bit scanner that walks one
// bitmap bit per cycle. Back to back, a data byte occupies the scanner
// until its last bit or the end of the glyph; when its last scanned bit
// and an earlier bit are both set, the scanner passes through its flush and
// idle states before the next beat is taken. Start beats and bytes with no
// glyph in progress are consumed without entering the scan state. Each
// pixel is held until the next set bit or the end of its byte. Throughput
// is set by the scanner. Reset clears the queue, the held pixel, the output
// register and all glyph state. When the receiver stalls, the output
// register holds its beat, the scanner holds at the next step that must
// push a pixel, and the queue keeps accepting until it is full.
module mono_glyph_bitmap_rasterizer_unit #(
  parameter int COLOR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mgbr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mgbr_pkg::out_item_t out_data
);
  import mgbr_pkg::*;

  // Queue between the classifier and the scanner.
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  mgbr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  // Scanner: glyph registers, bit walk and registered pixel output.
  mgbr_back #(
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_mono_glyph_bitmap_rasterizer_unit.sv -----
// Self-checking bench for the monochrome glyph rasteriser: random beats, own pixel predictor.
module tb_mono_glyph_bitmap_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mgbr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the input queue
  localparam int DRAIN_CYCLES = 64;   // covers the worst pixel latency and a long stall
  localparam int RANDOM_ITEMS = 145;
  localparam int MAX_REPORTS  = 10;

  // One pending input beat, the idle cycles to leave after it is taken, and a hold-off flag.
  typedef struct {
    in_item_t beat;
    int       gap;
    bit       hold;
  } beat_slot_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  mono_glyph_bitmap_rasterizer_unit #(
    .COLOR_BITS(COLOR_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Glyph state as the block should hold it; reset state is all zero.
  logic [COORD_W-1:0] gl_base_x = '0;
  logic [COORD_W-1:0] gl_base_y = '0;
  logic [COLOR_W-1:0] gl_color  = '0;
  logic [DIM_W-1:0]   gl_width  = '0;
  logic [DIM_W-1:0]   gl_height = '0;
  logic [DIM_W-1:0]   gl_col    = '0;
  logic [DIM_W-1:0]   gl_row    = '0;
  logic               gl_active = 1'b0;

  out_item_t  pixel_due[$];      // pixels still owed by the block, oldest first
  beat_slot_t beats_pending[$];  // input beats not yet offered

  int fault_cnt   = 0;
  int cycle_cnt   = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int holds_asked = 0;
  int holds_taken = 0;
  int rx_beats    = 0;
  bit in_fired    = 1'b0;
  bit out_fired   = 1'b0;

  // Work out the pixels that one accepted beat must produce.
  task automatic rasterise_beat(input in_item_t b);
    out_item_t px_buf[BYTE_W];
    int        n_px;
    int        i;
    n_px = 0;
    if (b.kind == CMD_START) begin
      // Latch the glyph and rewind; an unfinished glyph is simply dropped.
      gl_base_x = b.origin_x;
      gl_base_y = b.origin_y;
      gl_width  = b.glyph_width;
      gl_height = b.glyph_height;
      gl_color  = b.pixel_color;
      gl_col    = '0;
      gl_row    = '0;
      gl_active = (b.glyph_width != '0) && (b.glyph_height != '0);
    end else if (gl_active) begin
      // Walk the byte MSB first; stop as soon as the glyph is complete.
      for (i = 0; i < BYTE_W && gl_active; i++) begin
        if (b.data_byte[BYTE_W-1-i]) begin
          px_buf[n_px].pixel_x      = gl_base_x + COORD_W'(gl_col);
          px_buf[n_px].pixel_y      = gl_base_y + COORD_W'(gl_row);
          px_buf[n_px].out_color    = gl_color;
          px_buf[n_px].last_of_byte = 1'b0;
          n_px++;
        end
        gl_col = gl_col + 1'b1;
        if (gl_col >= gl_width) begin
          gl_col = '0;
          gl_row = gl_row + 1'b1;
          if (gl_row >= gl_height) begin
            gl_active = 1'b0;
          end
        end
      end
      if (n_px > 0) begin
        px_buf[n_px-1].last_of_byte = 1'b1;
      end
      for (i = 0; i < n_px; i++) begin
        pixel_due.push_back(px_buf[i]);
      end
    end
  endtask

  // Mostly back to back, some short gaps, the odd long one.
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 62) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return '0;
    end else if (r < 40) begin
      return '1;
    end else begin
      return BYTE_W'($urandom);
    end
  endfunction

  function automatic void add_start(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                    input logic [COLOR_W-1:0] c, input bit steady,
                                    input bit hold);
    beat_slot_t slot;
    slot.beat.kind         = CMD_START;
    slot.beat.origin_x     = x;
    slot.beat.origin_y     = y;
    slot.beat.glyph_width  = w;
    slot.beat.glyph_height = h;
    slot.beat.pixel_color  = c;
    slot.beat.data_byte    = BYTE_W'($urandom);  // unused on a start beat
    slot.gap               = pick_gap(steady);
    slot.hold              = hold;
    beats_pending.push_back(slot);
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] d, input bit steady);
    beat_slot_t   slot;
    logic [95:0]  noise;
    // Fill the fields that a data beat ignores with junk.
    noise               = {$urandom, $urandom, $urandom};
    slot.beat           = noise[$bits(in_item_t)-1:0];
    slot.beat.kind      = CMD_BYTE;
    slot.beat.data_byte = d;
    slot.gap            = pick_gap(steady);
    slot.hold           = 1'b0;
    beats_pending.push_back(slot);
  endfunction

  task automatic note_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Input side: record each accepted beat and predict its pixels.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      rasterise_beat(in_data);
      in_fired = 1'b1;
    end
  end

  // Driver: change inputs on the falling edge, hold valid and payload until taken.
  always @(negedge clk) begin : beat_driver
    beat_slot_t slot;
    logic       nxt_valid;
    in_item_t   nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst) begin
      if (in_fired) begin
        in_fired  = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (beats_pending.size() != 0) begin
          slot      = beats_pending.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = slot.beat;
          gap_left  = slot.gap;
          if (slot.hold) begin
            holds_asked++;
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Monitor: compare each accepted pixel with the oldest one owed.
  always @(posedge clk) begin : pixel_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      out_fired = 1'b1;
      if (pixel_due.size() == 0) begin
        note_fault($sformatf("unexpected pixel x=%0d y=%0d colour=%h last=%b",
                             out_data.pixel_x, out_data.pixel_y, out_data.out_color,
                             out_data.last_of_byte));
      end else begin
        want = pixel_due.pop_front();
        if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
            out_data.out_color !== want.out_color ||
            out_data.last_of_byte !== want.last_of_byte) begin
          note_fault($sformatf({"pixel mismatch: want x=%0d y=%0d colour=%h last=%b, ",
                                "got x=%0d y=%0d colour=%h last=%b"},
                               want.pixel_x, want.pixel_y, want.out_color, want.last_of_byte,
                               out_data.pixel_x, out_data.pixel_y, out_data.out_color,
                               out_data.last_of_byte));
        end
      end
    end
  end

  // Receiver: random stalls after taken beats, stall-free stretches of 64 beats,
  // and a long hold-off whenever the driver flags one.
  always @(negedge clk) begin : pixel_sink
    logic nxt_ready;
    if (holds_asked != holds_taken) begin
      holds_taken = holds_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (out_fired) begin
      out_fired = 1'b0;
      rx_beats++;
      stall_left = pick_gap(((rx_beats / 64) % 2) == 1);
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ready <= nxt_ready;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_mono_glyph_bitmap_rasterizer_unit: FAIL");
      $finish;
    end
  end

  initial begin : run_ctl
    int counted;
    int glyph_no;
    int w;
    int h;
    int nb;
    int k;
    int sel;
    int fate;
    bit steady;
    bit hold;

    // Directed: stray byte with no glyph in progress.
    add_byte(8'hFF, 1'b0);
    // Empty glyphs: zero width, then zero height; the bytes after them are dropped.
    add_start(16'h1234, 16'h0042, 8'd0, 8'd5, 16'hF800, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_start(16'h0010, 16'h0020, 8'd5, 8'd0, 16'h07E0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0);
    // 3x3 glyph across the positive x edge and at y = -1: bits past the glyph
    // in the second byte are dropped, and the third byte finds no glyph.
    add_start(16'h7FFE, 16'hFFFF, 8'd3, 8'd3, 16'hFFFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hAA, 1'b0);
    // Largest glyph, a few bytes only (one with no set bit), then abandoned.
    add_start(16'h8000, 16'h7FFF, 8'd255, 8'd255, 16'h0000, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h81, 1'b0);
    add_byte(8'h55, 1'b0);
    // Single-pixel glyph whose only bit is clear: glyph ends with no pixel.
    add_start(16'h0000, 16'h0000, 8'd1, 8'd1, 16'hA5A5, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_start(16'hFFFF, 16'h8000, 8'd1, 8'd1, 16'h5A5A, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0);
    // One full byte of pixels, wrapping x through zero.
    add_start(16'hFFF9, 16'h7FFF, 8'd8, 8'd1, 16'h001F, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0);

    // Random glyphs: mostly complete with random bitmaps, some cut short by the
    // next start, some with trailing bytes, a few empty, a few long and thin.
    counted  = 0;
    glyph_no = 0;
    while (counted < RANDOM_ITEMS) begin
      sel    = $urandom_range(0, 99);
      hold   = (glyph_no == 2) || (glyph_no == 11);
      steady = hold || ($urandom_range(0, 2) == 0);
      if (hold) begin
        w = 10;
        h = 10;
      end else if (sel < 6) begin
        if ($urandom_range(0, 1) == 0) begin
          w = 0;
          h = $urandom_range(0, 255);
        end else begin
          w = $urandom_range(1, 255);
          h = 0;
        end
      end else if (sel < 10) begin
        if ($urandom_range(0, 1) == 0) begin
          w = $urandom_range(120, 255);
          h = 1;
        end else begin
          w = 1;
          h = $urandom_range(120, 255);
        end
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
      add_start(COORD_W'($urandom), COORD_W'($urandom), DIM_W'(w), DIM_W'(h),
                COLOR_W'($urandom), steady, hold);
      counted++;
      nb = (w * h + 7) / 8;
      if (nb == 0) begin
        for (k = 0; k < $urandom_range(1, 2); k++) begin
          add_byte(pick_bits(), steady);
        end
      end else begin
        fate = $urandom_range(0, 99);
        if (fate < 10 && nb > 1) begin
          nb = $urandom_range(1, nb - 1);
        end
        for (k = 0; k < nb; k++) begin
          add_byte(pick_bits(), steady);
          counted++;
        end
        if (fate >= 90) begin
          for (k = 0; k < $urandom_range(1, 2); k++) begin
            add_byte(pick_bits(), steady);
          end
        end
      end
      glyph_no++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every beat offered and taken, every owed pixel seen, then a quiet spell.
    while (beats_pending.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (pixel_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("tb_mono_glyph_bitmap_rasterizer_unit: PASS");
    end else begin
      $display("tb_mono_glyph_bitmap_rasterizer_unit: FAIL");
    end
    $finish;
  end

endmodule
